// ===== sv/sme_pkg.sv =====
// Package for the stack-machine execute core: opcodes, status codes and types.
// No dependencies.
`timescale 1ns / 1ps
package sme_pkg;

	localparam int unsigned WordW = 32;
	localparam int unsigned OpcShift = 24;
	localparam logic [WordW-1:0] ImmMask = 32'h00FF_FFFF;

	typedef enum logic [7:0] {
		OP_HALT  = 8'd0,
		OP_PUSHC = 8'd1,
		OP_ADD   = 8'd2,
		OP_SUB   = 8'd3,
		OP_MUL   = 8'd4,
		OP_DIV   = 8'd5,
		OP_MOD   = 8'd6,
		OP_RDINT = 8'd7,
		OP_WRINT = 8'd8,
		OP_RDCHR = 8'd9,
		OP_WRCHR = 8'd10
	} opcode_t;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_HALT    = 3'd1,
		ST_UNDER   = 3'd2,
		ST_OVER    = 3'd3,
		ST_UNKNOWN = 3'd4,
		ST_DIVZERO = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_EXEC,
		S_DIV,
		S_OUT
	} state_t;

	// Request to the divider and its answer.
	typedef struct packed {
		logic             start;
		logic             want_rem;
		logic [WordW-1:0] a;
		logic [WordW-1:0] b;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [WordW-1:0] result;
	} div_rsp_t;

	function automatic logic [WordW-1:0] sext_byte(input logic [WordW-1:0] v);
		sext_byte = {{(WordW-8){v[7]}}, v[7:0]};
	endfunction

endpackage

// ===== sv/sme_div.sv =====
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on sme_pkg.
`timescale 1ns / 1ps
module sme_div (
	input  logic              clk,
	input  logic              arst_n,
	input  sme_pkg::div_req_t req,
	output sme_pkg::div_rsp_t rsp
);
	localparam int unsigned W = sme_pkg::WordW;

	logic         busy_q;
	logic [5:0]   cnt_q;
	logic [W-1:0] quo_q;
	logic [W:0]   rem_q;
	logic [W-1:0] dvs_q;
	logic         neg_q_q;
	logic         neg_r_q;
	logic         rem_sel_q;
	logic         done_q;
	logic [W-1:0] res_q;

	logic [W:0]   shifted;
	logic [W:0]   diff;
	logic [W-1:0] ma;
	logic [W-1:0] mb;

	// Magnitudes of the operands.
	assign ma = req.a[W-1] ? (~req.a + 1'b1) : req.a;
	assign mb = req.b[W-1] ? (~req.b + 1'b1) : req.b;

	// One restoring step.
	assign shifted = {rem_q[W-1:0], quo_q[W-1]};
	assign diff    = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'(W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q     <= ma;
			rem_q     <= '0;
			dvs_q     <= mb;
			neg_q_q   <= req.a[W-1] ^ req.b[W-1];
			neg_r_q   <= req.a[W-1];
			rem_sel_q <= req.want_rem;
		end else if (busy_q) begin
			if (!diff[W]) begin
				rem_q <= diff;
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
	end

	// Sign correction.
	always_comb begin
		if (rem_sel_q)
			res_q = neg_r_q ? (~rem_q[W-1:0] + 1'b1) : rem_q[W-1:0];
		else
			res_q = neg_q_q ? (~quo_q + 1'b1) : quo_q;
	end

	assign rsp.done   = done_q;
	assign rsp.result = res_q;

endmodule

// ===== sv/sme_stack.sv =====
// Stack memory: one synchronous write port and one registered read port.
// Depends on sme_pkg for the word width.
`timescale 1ns / 1ps
module sme_stack #(
	parameter int unsigned DEPTH = 1024
) (
	input  logic                         clk,
	input  logic                         we,
	input  logic [$clog2(DEPTH)-1:0]     waddr,
	input  logic [sme_pkg::WordW-1:0]    wdata,
	input  logic [$clog2(DEPTH)-1:0]     raddr,
	output logic [sme_pkg::WordW-1:0]    rdata
);
	logic [sme_pkg::WordW-1:0] mem [DEPTH];

	// Write, then registered read.
	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ===== sv/stack_machine_execute_core.sv =====
// Top level of the stack-machine execute core: sequencer, stack pointer and ALU.
// Depends on sme_pkg, sme_stack and sme_div.
`timescale 1ns / 1ps
// Channel | Direction | Ports
// input   | in        | in_valid, in_stall, instr, read_value
// output  | out       | out_word_valid, out_stall, status, out_valid, out_value, out_is_char
//
// A push, a halt or an instruction failing in decode goes from S_READ to S_OUT; a
// write passes through S_READ and S_EXEC; arithmetic reads both stack words in S_READ
// via the single memory read port, then S_EXEC; DIV and MOD with a nonzero divisor wait
// in S_DIV for the one-bit-per-cycle divider. One instruction is held at a time;
// a new word is taken in the cycle after the result has left the output register.
// Reset clears the stack pointer and control state; stack contents are not cleared.
module stack_machine_execute_core #(
	parameter int unsigned STACK_DEPTH = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] instr,
	input  logic signed [31:0] read_value,
	output logic        out_word_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic        out_valid,
	output logic signed [31:0] out_value,
	output logic        out_is_char
);
	localparam int unsigned AW = $clog2(STACK_DEPTH);
	localparam int unsigned PW = $clog2(STACK_DEPTH + 1);
	localparam int unsigned W  = sme_pkg::WordW;

	sme_pkg::state_t state_q, state_d;

	logic [PW-1:0] sp_q;
	logic [7:0]    op_q;
	logic [W-1:0]  instr_q;
	logic [W-1:0]  rd_q;
	logic [W-1:0]  b_q;
	logic          rd_phase_q;

	logic          we;
	logic [AW-1:0] waddr;
	logic [W-1:0]  wdata;
	logic [AW-1:0] raddr;
	logic [W-1:0]  rdata;

	sme_pkg::div_req_t dreq;
	sme_pkg::div_rsp_t drsp;

	logic [2:0]    st_q;
	logic          ov_q;
	logic [W-1:0]  val_q;
	logic          ch_q;

	logic          accept;
	logic          is_arith;
	logic          is_push;
	logic          is_pop;
	logic          need_read;
	logic [W-1:0]  push_val;
	logic [W-1:0]  arith_res;
	logic [2*W-1:0] prod;
	logic [PW-1:0] sp_m1;
	logic [PW-1:0] sp_m2;

	sme_stack #(.DEPTH(STACK_DEPTH)) u_stack (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata)
	);

	sme_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	assign accept  = in_valid && !in_stall;
	assign in_stall = (state_q != sme_pkg::S_IDLE);
	assign sp_m1 = sp_q - PW'(1);
	assign sp_m2 = sp_q - PW'(2);

	// Decode of the held instruction.
	always_comb begin
		is_arith = (op_q >= 8'(sme_pkg::OP_ADD)) && (op_q <= 8'(sme_pkg::OP_MOD));
		is_push  = (op_q == 8'(sme_pkg::OP_PUSHC)) || (op_q == 8'(sme_pkg::OP_RDINT))
			|| (op_q == 8'(sme_pkg::OP_RDCHR));
		is_pop   = (op_q == 8'(sme_pkg::OP_WRINT)) || (op_q == 8'(sme_pkg::OP_WRCHR));
		need_read = (is_arith && sp_q >= PW'(2)) || (is_pop && sp_q != '0);
		case (op_q)
			8'(sme_pkg::OP_PUSHC): push_val = {{8{instr_q[23]}}, instr_q[23:0]};
			8'(sme_pkg::OP_RDCHR): push_val = sme_pkg::sext_byte(rd_q);
			default:               push_val = rd_q;
		endcase
	end

	// Read address: top of stack first, then the word below.
	assign raddr = rd_phase_q ? sp_m2[AW-1:0] : sp_m1[AW-1:0];

	// Combinational ALU on a (rdata) and b (b_q) for the simple operations.
	assign prod = rdata * b_q;
	always_comb begin
		case (op_q)
			8'(sme_pkg::OP_ADD): arith_res = rdata + b_q;
			8'(sme_pkg::OP_SUB): arith_res = rdata - b_q;
			default:             arith_res = prod[W-1:0];
		endcase
	end

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		case (state_q)
			sme_pkg::S_IDLE: if (accept) state_d = sme_pkg::S_READ;
			sme_pkg::S_READ: begin
				if (!need_read) state_d = sme_pkg::S_OUT;
				else if (is_pop || rd_phase_q) state_d = sme_pkg::S_EXEC;
			end
			sme_pkg::S_EXEC: begin
				if ((op_q == 8'(sme_pkg::OP_DIV) || op_q == 8'(sme_pkg::OP_MOD))
					&& b_q != '0)
					state_d = sme_pkg::S_DIV;
				else
					state_d = sme_pkg::S_OUT;
			end
			sme_pkg::S_DIV: if (drsp.done) state_d = sme_pkg::S_OUT;
			sme_pkg::S_OUT: if (!out_stall) state_d = sme_pkg::S_IDLE;
			default: state_d = sme_pkg::S_IDLE;
		endcase
	end

	// Output-side combinational controls: memory write and divider start.
	always_comb begin
		we = 1'b0;
		waddr = sp_q[AW-1:0];
		wdata = push_val;
		dreq.start = 1'b0;
		dreq.want_rem = (op_q == 8'(sme_pkg::OP_MOD));
		dreq.a = rdata;
		dreq.b = b_q;
		case (state_q)
			sme_pkg::S_READ: begin
				if (is_push && sp_q < PW'(STACK_DEPTH)) we = 1'b1;
			end
			sme_pkg::S_EXEC: begin
				if (is_arith) begin
					waddr = sp_m2[AW-1:0];
					if (op_q == 8'(sme_pkg::OP_DIV) || op_q == 8'(sme_pkg::OP_MOD)) begin
						dreq.start = (b_q != '0);
					end else begin
						we = 1'b1;
						wdata = arith_res;
					end
				end
			end
			sme_pkg::S_DIV: begin
				// The pointer already dropped by one when the divider started.
				waddr = sp_m1[AW-1:0];
				wdata = drsp.result;
				we = drsp.done;
			end
			default: ;
		endcase
	end

	// Sequencer registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= sme_pkg::S_IDLE;
			sp_q       <= '0;
			rd_phase_q <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				sme_pkg::S_IDLE: rd_phase_q <= 1'b0;
				sme_pkg::S_READ: begin
					if (is_push && sp_q < PW'(STACK_DEPTH)) sp_q <= sp_q + PW'(1);
					if (is_pop && sp_q != '0) sp_q <= sp_m1;
					if (is_arith && sp_q >= PW'(2)) rd_phase_q <= 1'b1;
				end
				sme_pkg::S_EXEC: begin
					if (is_arith && !((op_q == 8'(sme_pkg::OP_DIV)
						|| op_q == 8'(sme_pkg::OP_MOD)) && b_q == '0))
						sp_q <= sp_m1;
				end
				default: ;
			endcase
		end
	end

	// Payload registers and the result word.
	always_ff @(posedge clk) begin
		case (state_q)
			sme_pkg::S_IDLE: begin
				if (accept) begin
					op_q    <= instr[31:sme_pkg::OpcShift];
					instr_q <= instr & sme_pkg::ImmMask;
					rd_q    <= read_value;
				end
			end
			sme_pkg::S_READ: begin
				ov_q <= 1'b0; val_q <= '0; ch_q <= 1'b0;
				st_q <= sme_pkg::ST_OK;
				if (op_q == 8'(sme_pkg::OP_HALT)) st_q <= sme_pkg::ST_HALT;
				else if (op_q > 8'(sme_pkg::OP_WRCHR)) st_q <= sme_pkg::ST_UNKNOWN;
				else if (is_push && sp_q >= PW'(STACK_DEPTH)) st_q <= sme_pkg::ST_OVER;
				else if (!is_push && !need_read) st_q <= sme_pkg::ST_UNDER;
			end
			sme_pkg::S_EXEC: begin
				// The popped word arrives from the memory in this cycle.
				if (is_pop) begin
					ov_q <= 1'b1;
					ch_q <= (op_q == 8'(sme_pkg::OP_WRCHR));
					val_q <= (op_q == 8'(sme_pkg::OP_WRCHR)) ? sme_pkg::sext_byte(rdata)
						: rdata;
				end else if ((op_q == 8'(sme_pkg::OP_DIV) || op_q == 8'(sme_pkg::OP_MOD))
					&& b_q == '0)
					st_q <= sme_pkg::ST_DIVZERO;
			end
			default: ;
		endcase
	end

	// Hold the first read word: memory data is valid in the cycle after the address.
	logic first_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) first_q <= 1'b0;
		else first_q <= (state_q == sme_pkg::S_READ) && !rd_phase_q && need_read;
	end
	always_ff @(posedge clk) begin
		if (first_q) b_q <= rdata;
	end

	assign out_word_valid = (state_q == sme_pkg::S_OUT);
	assign status      = st_q;
	assign out_valid   = ov_q;
	assign out_value   = val_q;
	assign out_is_char = ch_q;

endmodule

// ===== test/tb_stack_machine_execute_core.sv =====
// Testbench for the stack-machine execute core: directed and random instruction words
// checked against a behavioural stack predictor. Depends on sme_pkg and the core RTL.
`timescale 1ns / 1ps
module tb_stack_machine_execute_core;

	localparam int Depth = 1024;
	localparam longint CycleLimit = 400000;

	typedef struct {
		logic [31:0] instr;
		logic [31:0] rdval;
	} instr_word_t;

	typedef struct {
		sme_pkg::status_t st;
		logic        emit;
		logic [31:0] value;
		logic        is_char;
	} exec_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [31:0] instr = '0;
	logic signed [31:0] read_value = '0;
	logic out_word_valid;
	logic out_stall = 1'b0;
	logic [2:0] status;
	logic out_valid;
	logic signed [31:0] out_value;
	logic out_is_char;

	// Predictor state: a shadow copy of the stack.
	logic [31:0] shadow_stack [Depth];
	int shadow_sp = 0;
	// Rough depth of the stack as the generator sees it.
	int gen_sp = 0;

	instr_word_t pending_words[$];
	exec_result_t expected_results[$];
	int errors = 0;
	longint cycles = 0;
	bit stim_done = 1'b0;
	int burst_left = 0;
	int gap_left = 0;

	always #2 clk = ~clk;

	stack_machine_execute_core #(.STACK_DEPTH(Depth)) dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.instr(instr), .read_value(read_value),
		.out_word_valid(out_word_valid), .out_stall(out_stall),
		.status(status), .out_valid(out_valid),
		.out_value(out_value), .out_is_char(out_is_char)
	);

	function automatic logic [31:0] byte_to_word(input logic [31:0] v);
		return {{24{v[7]}}, v[7:0]};
	endfunction

	// Work out the result of one instruction and update the shadow stack.
	function automatic exec_result_t execute_instr(input instr_word_t w);
		exec_result_t r;
		logic [7:0] op;
		logic [31:0] a, b, q, ma, mb, res;
		r.st = sme_pkg::ST_OK; r.emit = 1'b0; r.value = '0; r.is_char = 1'b0;
		op = w.instr[31:24];
		res = '0;
		case (op)
			sme_pkg::OP_HALT: r.st = sme_pkg::ST_HALT;
			sme_pkg::OP_PUSHC, sme_pkg::OP_RDINT, sme_pkg::OP_RDCHR: begin
				if (op == sme_pkg::OP_PUSHC) res = {{8{w.instr[23]}}, w.instr[23:0]};
				else if (op == sme_pkg::OP_RDINT) res = w.rdval;
				else res = byte_to_word(w.rdval);
				if (shadow_sp >= Depth) r.st = sme_pkg::ST_OVER;
				else begin
					shadow_stack[shadow_sp] = res;
					shadow_sp++;
				end
			end
			sme_pkg::OP_ADD, sme_pkg::OP_SUB, sme_pkg::OP_MUL, sme_pkg::OP_DIV,
			sme_pkg::OP_MOD: begin
				if (shadow_sp < 2) r.st = sme_pkg::ST_UNDER;
				else begin
					b = shadow_stack[shadow_sp-1];
					a = shadow_stack[shadow_sp-2];
					if ((op == sme_pkg::OP_DIV || op == sme_pkg::OP_MOD) && b == '0)
						r.st = sme_pkg::ST_DIVZERO;
					else begin
						ma = a[31] ? -a : a;
						mb = b[31] ? -b : b;
						case (op)
							sme_pkg::OP_ADD: res = a + b;
							sme_pkg::OP_SUB: res = a - b;
							sme_pkg::OP_MUL: res = a * b;
							sme_pkg::OP_DIV: begin
								q = ma / mb;
								res = (a[31] != b[31]) ? -q : q;
							end
							default: begin
								q = ma % mb;
								res = a[31] ? -q : q;
							end
						endcase
						shadow_sp--;
						shadow_stack[shadow_sp-1] = res;
					end
				end
			end
			sme_pkg::OP_WRINT, sme_pkg::OP_WRCHR: begin
				if (shadow_sp == 0) r.st = sme_pkg::ST_UNDER;
				else begin
					shadow_sp--;
					r.emit = 1'b1;
					r.value = shadow_stack[shadow_sp];
					if (op == sme_pkg::OP_WRCHR) begin
						r.value = byte_to_word(r.value);
						r.is_char = 1'b1;
					end
				end
			end
			default: r.st = sme_pkg::ST_UNKNOWN;
		endcase
		return r;
	endfunction

	// Queue one word, tracking the stack depth the generator expects.
	task automatic queue_word(input logic [7:0] op, input logic [23:0] imm,
			input logic [31:0] rd);
		instr_word_t w;
		w.instr = {op, imm};
		w.rdval = rd;
		case (op)
			sme_pkg::OP_PUSHC, sme_pkg::OP_RDINT, sme_pkg::OP_RDCHR:
				if (gen_sp < Depth) gen_sp++;
			sme_pkg::OP_ADD, sme_pkg::OP_SUB, sme_pkg::OP_MUL: if (gen_sp >= 2) gen_sp--;
			sme_pkg::OP_WRINT, sme_pkg::OP_WRCHR: if (gen_sp > 0) gen_sp--;
			default: ;
		endcase
		pending_words.push_back(w);
	endtask

	// Push a value through RDINT or PUSHC, chosen at random.
	task automatic queue_push(input logic [31:0] v);
		if ($urandom_range(1)) queue_word(sme_pkg::OP_RDINT, 24'($urandom), v);
		else queue_word(sme_pkg::OP_PUSHC, v[23:0], $urandom);
	endtask

	// Stimulus: directed corners, random programs, then a fill past the top.
	initial begin
		logic [7:0] op;
		int n;
		// Directed: underflow on empty stack, halt, unknown opcodes.
		queue_word(sme_pkg::OP_WRINT, 24'h0, 32'h0);
		queue_word(sme_pkg::OP_ADD, 24'hFFFFFF, 32'hFFFFFFFF);
		queue_word(sme_pkg::OP_HALT, 24'hABCDEF, 32'h0);
		queue_word(8'd11, 24'h0, 32'h0);
		queue_word(8'd255, 24'hFFFFFF, 32'hFFFFFFFF);
		queue_word(sme_pkg::OP_PUSHC, 24'h7FFFFF, 32'h0);
		queue_word(sme_pkg::OP_PUSHC, 24'h800000, 32'h0);
		queue_word(sme_pkg::OP_ADD, 24'h0, 32'h0);
		queue_word(sme_pkg::OP_WRINT, 24'h0, 32'h0);
		queue_word(sme_pkg::OP_RDINT, 24'h0, 32'h80000000);
		queue_word(sme_pkg::OP_PUSHC, 24'hFFFFFF, 32'h0);
		queue_word(sme_pkg::OP_DIV, 24'h0, 32'h0);       // most negative over minus one
		queue_word(sme_pkg::OP_RDINT, 24'h0, 32'h80000000);
		queue_word(sme_pkg::OP_PUSHC, 24'hFFFFFF, 32'h0);
		queue_word(sme_pkg::OP_MOD, 24'h0, 32'h0);
		queue_word(sme_pkg::OP_PUSHC, 24'h0, 32'h0);
		queue_word(sme_pkg::OP_DIV, 24'h0, 32'h0);       // divide by zero
		queue_word(sme_pkg::OP_MOD, 24'h0, 32'h0);
		queue_word(sme_pkg::OP_SUB, 24'h0, 32'h0);
		queue_word(sme_pkg::OP_RDCHR, 24'h0, 32'h123456FF);
		queue_word(sme_pkg::OP_MUL, 24'h0, 32'h0);
		queue_word(sme_pkg::OP_RDCHR, 24'h0, 32'h0000007F);
		queue_word(sme_pkg::OP_WRCHR, 24'h0, 32'h0);
		queue_word(sme_pkg::OP_WRCHR, 24'h0, 32'h0);
		queue_word(sme_pkg::OP_WRINT, 24'h0, 32'h0);
		// Random programs near the bottom of the stack: mostly well formed, some noise.
		n = 0;
		while (n < 600) begin
			case ($urandom_range(15))
				0: op = $urandom_range(2) == 0 ? sme_pkg::OP_HALT
					: 8'($urandom_range(255, 11));
				1, 2, 3, 4: op = sme_pkg::OP_PUSHC;
				5: op = sme_pkg::OP_RDINT;
				6: op = sme_pkg::OP_RDCHR;
				7: op = sme_pkg::OP_ADD;
				8: op = sme_pkg::OP_SUB;
				9: op = sme_pkg::OP_MUL;
				10, 11: op = sme_pkg::OP_DIV;
				12: op = sme_pkg::OP_MOD;
				13: op = sme_pkg::OP_WRINT;
				default: op = sme_pkg::OP_WRCHR;
			endcase
			if (op == sme_pkg::OP_PUSHC && $urandom_range(7) == 0)
				queue_word(op, $urandom_range(1) ? 24'h0 : 24'hFFFFFF, $urandom);
			else if ((op == sme_pkg::OP_DIV || op == sme_pkg::OP_MOD) && gen_sp >= 2)
				queue_word(op, 24'($urandom), $urandom);
			else
				queue_word(op, 24'($urandom), $urandom_range(3) == 0 ? 32'h0 : $urandom);
			n++;
		end
		// Fill to the top from any depth and overflow.
		repeat (Depth + 2) queue_push($urandom);
		queue_word(sme_pkg::OP_PUSHC, 24'h1, 32'h0);
		queue_word(sme_pkg::OP_RDINT, 24'h0, 32'h1);
		queue_word(sme_pkg::OP_RDCHR, 24'h0, 32'h1);
		queue_word(sme_pkg::OP_ADD, 24'h0, 32'h0);
		stim_done = 1'b1;
	end

	// Hold reset, then release it once.
	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Driver: bursts of words with random gaps; predict each word as it is accepted.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				expected_results.push_back(execute_instr(pending_words.pop_front()));
			end
			if (in_valid && in_stall) begin
				// Hold the stalled word.
			end else if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				in_valid <= 1'b0;
			end else if (pending_words.size() > 0) begin
				in_valid <= 1'b1;
				instr <= pending_words[0].instr;
				read_value <= pending_words[0].rdval;
				if (burst_left == 0) begin
					burst_left <= $urandom_range(20, 1);
					if ($urandom_range(3) != 0) gap_left <= $urandom_range(6);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Monitor and receiver stall pattern.
	always @(posedge clk) begin
		exec_result_t e;
		cycles <= cycles + 1;
		if (arst_n) begin
			out_stall <= ((cycles / 300) % 3 == 0) ? 1'b0 : ($urandom_range(4) == 0);
			if (out_word_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result word, status %0d", $time, status);
					errors++;
				end else begin
					e = expected_results.pop_front();
					if (status !== e.st) begin
						$display("%0t: status expected %0d actual %0d", $time, e.st, status);
						errors++;
					end
					if (out_valid !== e.emit) begin
						$display("%0t: out_valid expected %0b actual %0b", $time, e.emit,
							out_valid);
						errors++;
					end
					if (out_value !== e.value) begin
						$display("%0t: out_value expected %h actual %h", $time, e.value,
							out_value);
						errors++;
					end
					if (out_is_char !== e.is_char) begin
						$display("%0t: out_is_char expected %0b actual %0b", $time,
							e.is_char, out_is_char);
						errors++;
					end
				end
			end
		end
	end

	// End of run: drain, allow for the latency, then report.
	initial begin
		wait (stim_done && pending_words.size() == 0 && !in_valid
			&& expected_results.size() == 0);
		repeat (60) @(posedge clk);
		if (errors == 0 && expected_results.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// Timeout.
	always @(posedge clk) begin
		if (cycles > CycleLimit) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

endmodule

// ===== filelist.f =====
sv/sme_pkg.sv
sv/sme_div.sv
sv/sme_stack.sv
sv/stack_machine_execute_core.sv
test/tb_stack_machine_execute_core.sv
